// ----- rtl/htdm_pkg.sv -----
// Shared types, widths and constants of the thermostat duty meter.
`timescale 1ns / 1ps
`default_nettype none

package htdm_pkg;

  // Field widths
  localparam int CNT_W      = 32;
  localparam int OUT_W      = 32;
  localparam int TEMP_W     = 12;
  localparam int DT_W       = 16;
  localparam int WATT_W     = 16;
  localparam int PCT_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Energy path: chill seconds times watts over 3600 = 16 * 225. Drop four bits,
  // then divide by 225 in two 22-bit digits, each by a reciprocal multiply.
  localparam int     PROD_W   = CNT_W + WATT_W;
  localparam int     WH_SHIFT = 4;
  localparam int     WH_ODD   = 225;
  localparam int     WX_W     = PROD_W - WH_SHIFT;
  localparam int     WCH_W    = WX_W / 2;
  localparam int     WREM_W   = $clog2(WH_ODD);
  localparam int     RCP_IN_W = WREM_W + WCH_W;
  localparam int     RCP_SH   = RCP_IN_W + WREM_W;
  localparam longint RCP_M    = ((longint'(1) << RCP_SH) + WH_ODD - 1) / WH_ODD;
  localparam int     RCP_M_W  = RCP_SH - WREM_W + 1;
  localparam int     RCP_P_W  = RCP_IN_W + RCP_M_W;
  localparam int     RCP_Q_W  = RCP_P_W - RCP_SH;
  localparam int     WQ_W     = RCP_Q_W + WCH_W;

  // Percentage path: chill times 100 over runtime, quotient never above 100
  localparam int PCT_SCALE  = 100;
  localparam int PCT_MUL_W  = 7;
  localparam int PCT_NUM_W  = CNT_W + PCT_MUL_W;
  localparam int PCT_Q_W    = PCT_MUL_W + 1;
  localparam int PCT_STEPS  = PCT_Q_W;
  localparam int STEP_CNT_W = $clog2(PCT_STEPS);

  // Queue between front and back
  localparam int Q_DEPTH    = 2;
  localparam int QPTR_W     = $clog2(Q_DEPTH);

  // Register reset values
  localparam logic signed [TEMP_W-1:0] HIGH_THR_RST = 12'sd64;
  localparam logic signed [TEMP_W-1:0] LOW_THR_RST  = 12'sd58;
  localparam logic [WATT_W-1:0]        WATTS_RST    = 16'd85;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HIGH_THR = 2'd0,
    REG_LOW_THR  = 2'd1,
    REG_WATTS    = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_DONE
  } back_state_e;

  typedef struct packed {
    logic [DT_W-1:0]          elapsed_seconds;
    logic signed [TEMP_W-1:0] temperature;
  } in_item_t;

  typedef struct packed {
    logic              compressor_on;
    logic [OUT_W-1:0]  runtime_seconds;
    logic [OUT_W-1:0]  chill_seconds;
    logic [PCT_W-1:0]  chill_percent;
    logic [OUT_W-1:0]  watt_hours;
  } out_item_t;

  typedef struct packed {
    logic             compressor_on;
    logic [CNT_W-1:0] runtime;
    logic [CNT_W-1:0] chill;
  } q_entry_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

// ----- rtl/htdm_in_if.sv -----
// Input channel of the thermostat duty meter: one control tick per item.
`timescale 1ns / 1ps
`default_nettype none

interface htdm_in_if;
  logic               valid;
  logic               ready;
  htdm_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/htdm_out_if.sv -----
// Output channel of the thermostat duty meter: one result per tick.
`timescale 1ns / 1ps
`default_nettype none

interface htdm_out_if;
  logic                valid;
  logic                ready;
  htdm_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/htdm_front.sv -----
// Front: accept ticks, update totals and hysteresis state, push snapshots.
`timescale 1ns / 1ps
`default_nettype none

module htdm_front (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  htdm_in_if.sink                                    in_i,
  input  wire logic signed [htdm_pkg::TEMP_W-1:0]    high_thr_i,
  input  wire logic signed [htdm_pkg::TEMP_W-1:0]    low_thr_i,
  input  wire htdm_pkg::q_status_t                   q_status_i,
  output logic                                       push_o,
  output htdm_pkg::q_entry_t                         entry_o
);

  logic                           on_q, on_d;
  logic [htdm_pkg::CNT_W-1:0]     runtime_q, runtime_d;
  logic [htdm_pkg::CNT_W-1:0]     chill_q, chill_d;
  logic [htdm_pkg::CNT_W:0]       rt_sum, ch_sum;
  logic                           accept;

  // Take an item whenever the queue has room
  assign in_i.ready = !q_status_i.full;
  assign accept     = in_i.valid && !q_status_i.full;

  // Saturating totals; chill counts only if the compressor was on before the tick
  always_comb begin
    rt_sum    = {1'b0, runtime_q} + (htdm_pkg::CNT_W + 1)'(in_i.data.elapsed_seconds);
    ch_sum    = {1'b0, chill_q} + (htdm_pkg::CNT_W + 1)'(in_i.data.elapsed_seconds);
    runtime_d = rt_sum[htdm_pkg::CNT_W] ? '1 : rt_sum[htdm_pkg::CNT_W-1:0];
    if (on_q) begin
      chill_d = ch_sum[htdm_pkg::CNT_W] ? '1 : ch_sum[htdm_pkg::CNT_W-1:0];
    end else begin
      chill_d = chill_q;
    end
  end

  // Hysteresis: test for on only while off, for off only while on
  always_comb begin
    if (on_q) begin
      on_d = !(in_i.data.temperature < low_thr_i);
    end else begin
      on_d = in_i.data.temperature > high_thr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_q      <= 1'b0;
      runtime_q <= '0;
      chill_q   <= '0;
    end else if (accept) begin
      on_q      <= on_d;
      runtime_q <= runtime_d;
      chill_q   <= chill_d;
    end
  end

  // Hand the post-tick snapshot to the back
  assign push_o                = accept;
  assign entry_o.compressor_on = on_d;
  assign entry_o.runtime       = runtime_d;
  assign entry_o.chill         = chill_d;

endmodule

`default_nettype wire

// ----- rtl/htdm_queue.sv -----
// Two-entry queue of tick snapshots between front and back.
`timescale 1ns / 1ps
`default_nettype none

module htdm_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire htdm_pkg::q_entry_t   entry_i,
  input  wire logic                 pop_i,
  output htdm_pkg::q_entry_t        entry_o,
  output htdm_pkg::q_status_t       status_o
);

  htdm_pkg::q_entry_t              slot_q [htdm_pkg::Q_DEPTH];
  logic [htdm_pkg::QPTR_W-1:0]     wptr_q, rptr_q;
  logic [htdm_pkg::QPTR_W:0]       count_q;
  logic                            do_push, do_pop;

  assign status_o.full  = (count_q == (htdm_pkg::QPTR_W + 1)'(htdm_pkg::Q_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign entry_o        = slot_q[rptr_q];

  // Store the pushed snapshot
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= entry_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/htdm_back.sv -----
// Back: percentage division and reciprocal watt-hour divide on a snapshot, then hold the result.
`timescale 1ns / 1ps
`default_nettype none

module htdm_back (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [htdm_pkg::WATT_W-1:0]    watts_i,
  input  wire htdm_pkg::q_status_t            q_status_i,
  input  wire htdm_pkg::q_entry_t             entry_i,
  output logic                                pop_o,
  htdm_out_if.source                          out_o
);

  localparam logic [htdm_pkg::RCP_M_W-1:0] RcpMC   = htdm_pkg::RCP_M_W'(htdm_pkg::RCP_M);
  localparam logic [htdm_pkg::WREM_W-1:0]  WhOddC  = htdm_pkg::WREM_W'(htdm_pkg::WH_ODD);
  localparam logic [htdm_pkg::PCT_Q_W-1:0] PctMaxC = htdm_pkg::PCT_Q_W'(htdm_pkg::PCT_SCALE);
  localparam logic [htdm_pkg::STEP_CNT_W-1:0] LastStepC =
    htdm_pkg::STEP_CNT_W'(htdm_pkg::PCT_STEPS - 1);
  localparam logic [htdm_pkg::STEP_CNT_W-1:0] WhHiStepC  = htdm_pkg::STEP_CNT_W'(0);
  localparam logic [htdm_pkg::STEP_CNT_W-1:0] WhRemStepC = htdm_pkg::STEP_CNT_W'(1);
  localparam logic [htdm_pkg::STEP_CNT_W-1:0] WhLoStepC  = htdm_pkg::STEP_CNT_W'(2);

  htdm_pkg::back_state_e state_q, state_d;
  logic [htdm_pkg::STEP_CNT_W-1:0] step_q;

  // Snapshot and division registers
  logic                              on_q;
  logic [htdm_pkg::CNT_W-1:0]        rt_q, ch_q;
  logic [htdm_pkg::WX_W-1:0]         wh_q;
  logic [htdm_pkg::RCP_Q_W-1:0]      wqh_q;
  logic [htdm_pkg::RCP_IN_W-1:0]     wy_q;
  logic [htdm_pkg::WCH_W-1:0]        wql_q;
  logic [htdm_pkg::PCT_NUM_W-1:0]    prem_q, dsh_q;
  logic [htdm_pkg::PCT_Q_W-1:0]      pquo_q;

  // Step results
  logic [htdm_pkg::PROD_W-1:0]       wprod;
  logic [htdm_pkg::WCH_W-1:0]        wx_hi, wqh_mul;
  logic [htdm_pkg::RCP_IN_W-1:0]     rcp_in;
  logic [htdm_pkg::RCP_P_W-1:0]      rcp_prod;
  logic [htdm_pkg::RCP_Q_W-1:0]      rcp_q;
  logic [htdm_pkg::WREM_W-1:0]       wrem;
  logic                              pge;

  // Final formatting
  logic [htdm_pkg::WQ_W-1:0]         wq;
  logic [htdm_pkg::PCT_W-1:0]        pct_fin;
  logic [htdm_pkg::OUT_W-1:0]        wh_fin;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      htdm_pkg::BK_IDLE: begin
        if (!q_status_i.empty) begin
          state_d = htdm_pkg::BK_MUL;
        end
      end
      htdm_pkg::BK_MUL:  state_d = htdm_pkg::BK_DIV;
      htdm_pkg::BK_DIV: begin
        if (step_q == LastStepC) begin
          state_d = htdm_pkg::BK_DONE;
        end
      end
      htdm_pkg::BK_DONE: begin
        if (out_o.ready) begin
          state_d = htdm_pkg::BK_IDLE;
        end
      end
      default: state_d = htdm_pkg::BK_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    pop_o       = 1'b0;
    out_o.valid = 1'b0;
    unique case (state_q)
      htdm_pkg::BK_IDLE: pop_o       = !q_status_i.empty;
      htdm_pkg::BK_DONE: out_o.valid = 1'b1;
      default: begin
        pop_o       = 1'b0;
        out_o.valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= htdm_pkg::BK_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == htdm_pkg::BK_DIV) begin
        step_q <= step_q + 1'b1;
      end else begin
        step_q <= '0;
      end
    end
  end

  // Energy product, then divide by 225 one 22-bit digit at a time by reciprocal multiply
  always_comb begin
    wprod    = htdm_pkg::PROD_W'(ch_q) * htdm_pkg::PROD_W'(watts_i);
    wx_hi    = wh_q[htdm_pkg::WX_W-1:htdm_pkg::WCH_W];
    rcp_in   = (step_q == WhHiStepC) ? htdm_pkg::RCP_IN_W'(wx_hi) : wy_q;
    rcp_prod = htdm_pkg::RCP_P_W'(rcp_in) * htdm_pkg::RCP_P_W'(RcpMC);
    rcp_q    = rcp_prod[htdm_pkg::RCP_P_W-1:htdm_pkg::RCP_SH];
    wqh_mul  = htdm_pkg::WCH_W'(wqh_q * WhOddC);
    wrem     = htdm_pkg::WREM_W'(wx_hi - wqh_mul);
  end

  // One quotient bit of the percentage per cycle against a shifting divisor
  assign pge = (prem_q >= dsh_q);

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      htdm_pkg::BK_IDLE: begin
        if (!q_status_i.empty) begin
          on_q <= entry_i.compressor_on;
          rt_q <= entry_i.runtime;
          ch_q <= entry_i.chill;
        end
      end
      htdm_pkg::BK_MUL: begin
        wh_q   <= wprod[htdm_pkg::PROD_W-1:htdm_pkg::WH_SHIFT];
        prem_q <= htdm_pkg::PCT_NUM_W'(ch_q) * htdm_pkg::PCT_NUM_W'(htdm_pkg::PCT_SCALE);
        dsh_q  <= htdm_pkg::PCT_NUM_W'(rt_q) << (htdm_pkg::PCT_Q_W - 1);
        pquo_q <= '0;
      end
      htdm_pkg::BK_DIV: begin
        if (step_q == WhHiStepC) begin
          wqh_q <= rcp_q;
        end
        if (step_q == WhRemStepC) begin
          wy_q <= {wrem, wh_q[htdm_pkg::WCH_W-1:0]};
        end
        if (step_q == WhLoStepC) begin
          wql_q <= rcp_q[htdm_pkg::WCH_W-1:0];
        end
        if (pge) begin
          prem_q <= prem_q - dsh_q;
        end
        pquo_q <= {pquo_q[htdm_pkg::PCT_Q_W-2:0], pge};
        dsh_q  <= dsh_q >> 1;
      end
      default: begin
        wh_q <= wh_q;
      end
    endcase
  end

  // Zero runtime gives zero percent; cap and saturate the results
  always_comb begin
    wq = {wqh_q, wql_q};
    if (rt_q == '0) begin
      pct_fin = '0;
    end else if (pquo_q > PctMaxC) begin
      pct_fin = htdm_pkg::PCT_W'(htdm_pkg::PCT_SCALE);
    end else begin
      pct_fin = pquo_q[htdm_pkg::PCT_W-1:0];
    end
    wh_fin = (|wq[htdm_pkg::WQ_W-1:htdm_pkg::OUT_W]) ? '1 : wq[htdm_pkg::OUT_W-1:0];
  end

  assign out_o.data.compressor_on   = on_q;
  assign out_o.data.runtime_seconds = rt_q;
  assign out_o.data.chill_seconds   = ch_q;
  assign out_o.data.chill_percent   = pct_fin;
  assign out_o.data.watt_hours      = wh_fin;

endmodule

`default_nettype wire

// ----- rtl/hysteresis_thermostat_duty_meter.sv -----
// Top level of the hysteresis thermostat with duty and energy meter.
//
//   channel  direction  handshake      payload
//   in_i     sink       valid/ready    elapsed_seconds, temperature
//   out_o    source     valid/ready    compressor_on, runtime/chill seconds,
//                                      chill_percent, watt_hours
//   cfg      write      cfg_we_i       cfg_idx_i, cfg_data_i
//
// The front takes a tick and pushes a snapshot into a two-entry queue.
// The back loads a snapshot, multiplies, then forms the eight percent bits (one a cycle;
// the divide by 225 runs as reciprocal multiplies in the first three steps), and holds
// the result in the output register until out_o.ready before it takes the next one.
// Ticks keep entering until the queue is full, also while a result waits.
// Reset: asynchronous, active low; totals zero, compressor off, registers at defaults.
`timescale 1ns / 1ps
`default_nettype none

module hysteresis_thermostat_duty_meter (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  htdm_in_if.sink                                  in_i,
  htdm_out_if.source                               out_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [htdm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [htdm_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  logic signed [htdm_pkg::TEMP_W-1:0] high_thr_q, low_thr_q;
  logic [htdm_pkg::WATT_W-1:0]        watts_q;

  htdm_pkg::q_status_t q_status;
  htdm_pkg::q_entry_t  push_entry, pop_entry;
  logic                push, pop;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_thr_q <= htdm_pkg::HIGH_THR_RST;
      low_thr_q  <= htdm_pkg::LOW_THR_RST;
      watts_q    <= htdm_pkg::WATTS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        htdm_pkg::REG_HIGH_THR: high_thr_q <= cfg_data_i[htdm_pkg::TEMP_W-1:0];
        htdm_pkg::REG_LOW_THR:  low_thr_q  <= cfg_data_i[htdm_pkg::TEMP_W-1:0];
        htdm_pkg::REG_WATTS:    watts_q    <= cfg_data_i[htdm_pkg::WATT_W-1:0];
        default:                watts_q    <= watts_q;
      endcase
    end
  end

  htdm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .high_thr_i (high_thr_q),
    .low_thr_i  (low_thr_q),
    .q_status_i (q_status),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  htdm_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .entry_o  (pop_entry),
    .status_o (q_status)
  );

  htdm_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .watts_i    (watts_q),
    .q_status_i (q_status),
    .entry_i    (pop_entry),
    .pop_o      (pop),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire

// ----- rtl/htdm_checker.sv -----
// Port checker for the thermostat duty meter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module htdm_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire htdm_pkg::out_item_t out_data
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Percentage never passes the full scale
  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_data.chill_percent <= htdm_pkg::PCT_W'(htdm_pkg::PCT_SCALE))
    else $error("chill percent above full scale");

  // Chill time is part of runtime
  a_chill_le_rt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_data.chill_seconds <= out_data.runtime_seconds)
    else $error("chill seconds exceed runtime");

  // No runtime means no chill, no percent and no energy
  a_zero_rt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.runtime_seconds == '0 |->
      out_data.chill_percent == '0 && out_data.watt_hours == '0)
    else $error("nonzero result with zero runtime");

endmodule

bind hysteresis_thermostat_duty_meter htdm_checker u_htdm_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_data  (out_o.data)
);

`default_nettype wire

// ----- dv/hysteresis_thermostat_duty_meter_tb.sv -----
// Self-checking testbench for the hysteresis thermostat with duty and energy meter.
`timescale 1ns / 1ps

module hysteresis_thermostat_duty_meter_tb;

  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int TEMP_MIN      = -880;
  localparam int TEMP_MAX      = 2000;
  localparam int DT_MAX        = 65535;
  localparam int WATTS_MAX     = 65535;
  localparam int RAND_PHASES   = 8;
  localparam int PHASE_TICKS   = 150;
  localparam int SOAK_TICKS    = 300;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [htdm_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [htdm_pkg::CFG_DATA_W-1:0] cfg_data_i;

  htdm_in_if  tick_if ();
  htdm_out_if res_if ();

  hysteresis_thermostat_duty_meter uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (tick_if),
    .out_o      (res_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Thermostat settings and totals as the block should hold them
  logic signed [htdm_pkg::TEMP_W-1:0] thr_high;
  logic signed [htdm_pkg::TEMP_W-1:0] thr_low;
  logic [htdm_pkg::WATT_W-1:0]        watts;
  logic                               comp_on;
  logic [htdm_pkg::CNT_W-1:0]         run_total;
  logic [htdm_pkg::CNT_W-1:0]         chill_total;

  htdm_pkg::in_item_t  tick_q[$];
  htdm_pkg::out_item_t due_readings[$];
  int                  fails;
  int                  cycles;
  bit                  steady;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Saturating add of elapsed seconds to a total
  function automatic logic [htdm_pkg::CNT_W-1:0] sat_total(
    logic [htdm_pkg::CNT_W-1:0] acc,
    logic [htdm_pkg::DT_W-1:0]  dt
  );
    logic [htdm_pkg::CNT_W:0] sum;
    sum = {1'b0, acc} + (htdm_pkg::CNT_W + 1)'(dt);
    return sum[htdm_pkg::CNT_W] ? '1 : sum[htdm_pkg::CNT_W-1:0];
  endfunction

  // Account one tick, run the hysteresis control and form the reading
  function automatic htdm_pkg::out_item_t thermo_tick(htdm_pkg::in_item_t t);
    logic [63:0]         pct;
    logic [63:0]         wh;
    htdm_pkg::out_item_t r;
    run_total = sat_total(run_total, t.elapsed_seconds);
    if (comp_on) begin
      chill_total = sat_total(chill_total, t.elapsed_seconds);
    end
    if ($signed(t.temperature) > thr_high && !comp_on) begin
      comp_on = 1'b1;
    end else if ($signed(t.temperature) < thr_low && comp_on) begin
      comp_on = 1'b0;
    end
    pct = '0;
    if (run_total != '0) begin
      pct = ({32'd0, chill_total} * 64'd100) / {32'd0, run_total};
      if (pct > 64'd100) begin
        pct = 64'd100;
      end
    end
    wh = ({32'd0, chill_total} * {48'd0, watts}) / 64'd3600;
    if (wh > 64'hFFFF_FFFF) begin
      wh = 64'hFFFF_FFFF;
    end
    r.compressor_on   = comp_on;
    r.runtime_seconds = run_total;
    r.chill_seconds   = chill_total;
    r.chill_percent   = pct[htdm_pkg::PCT_W-1:0];
    r.watt_hours      = wh[htdm_pkg::OUT_W-1:0];
    return r;
  endfunction

  // Compare one reading against the oldest outstanding one
  task automatic check_reading(htdm_pkg::out_item_t got);
    htdm_pkg::out_item_t want;
    if (due_readings.size() == 0) begin
      $error("reading with no tick outstanding");
      fails++;
      return;
    end
    want = due_readings.pop_front();
    if (got.compressor_on !== want.compressor_on) begin
      $error("compressor_on: expected %0d, actual %0d", want.compressor_on, got.compressor_on);
      fails++;
    end
    if (got.runtime_seconds !== want.runtime_seconds) begin
      $error("runtime_seconds: expected %0d, actual %0d",
             want.runtime_seconds, got.runtime_seconds);
      fails++;
    end
    if (got.chill_seconds !== want.chill_seconds) begin
      $error("chill_seconds: expected %0d, actual %0d", want.chill_seconds, got.chill_seconds);
      fails++;
    end
    if (got.chill_percent !== want.chill_percent) begin
      $error("chill_percent: expected %0d, actual %0d", want.chill_percent, got.chill_percent);
      fails++;
    end
    if (got.watt_hours !== want.watt_hours) begin
      $error("watt_hours: expected %0d, actual %0d", want.watt_hours, got.watt_hours);
      fails++;
    end
  endtask

  // Driver: present pending ticks, predict each one as it is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_if.valid <= 1'b0;
    end else begin
      if (tick_if.valid && tick_if.ready) begin
        due_readings.push_back(thermo_tick(tick_if.data));
      end
      if (!tick_if.valid || tick_if.ready) begin
        if (tick_q.size() != 0 && (steady || $urandom_range(99) >= 34)) begin
          tick_if.data  <= tick_q.pop_front();
          tick_if.valid <= 1'b1;
        end else begin
          tick_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: take readings with random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        check_reading(res_if.data);
      end
      res_if.ready <= steady || ($urandom_range(99) >= 34);
    end
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic add_tick(int dt, int temp);
    htdm_pkg::in_item_t t;
    t.elapsed_seconds = dt[htdm_pkg::DT_W-1:0];
    t.temperature     = temp[htdm_pkg::TEMP_W-1:0];
    tick_q.push_back(t);
  endtask

  // Hold off until every tick is taken and every reading is back
  task automatic drain();
    while (tick_q.size() != 0 || tick_if.valid || due_readings.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write all three registers and track them
  task automatic set_thermostat(int hi, int lo, int w);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= htdm_pkg::REG_HIGH_THR;
    cfg_data_i <= hi[htdm_pkg::CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_idx_i  <= htdm_pkg::REG_LOW_THR;
    cfg_data_i <= lo[htdm_pkg::CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_idx_i  <= htdm_pkg::REG_WATTS;
    cfg_data_i <= w[htdm_pkg::CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    thr_high = hi[htdm_pkg::TEMP_W-1:0];
    thr_low  = lo[htdm_pkg::TEMP_W-1:0];
    watts    = w[htdm_pkg::WATT_W-1:0];
  endtask

  function automatic int clamp_temp(int v);
    if (v < TEMP_MIN) return TEMP_MIN;
    if (v > TEMP_MAX) return TEMP_MAX;
    return v;
  endfunction

  // Mostly hover near a threshold so the compressor keeps switching
  function automatic int pick_temp();
    int anchor;
    if ($urandom_range(99) < 70) begin
      anchor = $urandom_range(1) ? int'(thr_high) : int'(thr_low);
      return clamp_temp(anchor + int'($urandom_range(40)) - 20);
    end
    return int'($urandom_range(TEMP_MAX - TEMP_MIN)) + TEMP_MIN;
  endfunction

  function automatic int pick_dt();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 0;
    if (r < 25) return DT_MAX;
    if (r < 45) return $urandom_range(15);
    return $urandom_range(DT_MAX);
  endfunction

  initial begin
    int hi;
    int lo;
    int w;
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = htdm_pkg::REG_HIGH_THR;
    cfg_data_i       = '0;
    tick_if.valid    = 1'b0;
    tick_if.data     = '0;
    res_if.ready     = 1'b0;
    fails            = 0;
    cycles           = 0;
    steady           = 1'b0;
    thr_high         = htdm_pkg::HIGH_THR_RST;
    thr_low          = htdm_pkg::LOW_THR_RST;
    watts            = htdm_pkg::WATTS_RST;
    comp_on          = 1'b0;
    run_total        = '0;
    chill_total      = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: zero runtime, equal-to-threshold holds, switching both ways
    add_tick(0, 0);
    add_tick(0, 65);
    add_tick(DT_MAX, 64);
    add_tick(100, 58);
    add_tick(1, 57);
    add_tick(DT_MAX, TEMP_MAX);
    add_tick(DT_MAX, TEMP_MIN);
    add_tick(0, 64);
    add_tick(12345, 65);
    add_tick(3600, 100);
    add_tick(7, -1);
    drain();

    // Crossed thresholds: an on compressor drops even above the high mark
    set_thermostat(10, 50, 0);
    add_tick(5, 30);
    add_tick(5, 30);
    add_tick(5, 30);
    add_tick(5, TEMP_MAX);
    add_tick(5, TEMP_MIN);
    add_tick(0, 11);
    drain();

    // Random phases, each under its own settings
    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p == 0) begin
        hi = TEMP_MAX;
        lo = TEMP_MIN;
        w  = WATTS_MAX;
      end else if (p == 1) begin
        hi = TEMP_MIN;
        lo = TEMP_MAX;
        w  = 0;
      end else begin
        hi = int'($urandom_range(TEMP_MAX - TEMP_MIN)) + TEMP_MIN;
        if ($urandom_range(99) < 75) begin
          lo = clamp_temp(hi - int'($urandom_range(64)));
        end else begin
          lo = int'($urandom_range(TEMP_MAX - TEMP_MIN)) + TEMP_MIN;
        end
        w = $urandom_range(WATTS_MAX);
      end
      set_thermostat(hi, lo, w);
      steady = (p == 3);
      for (int i = 0; i < PHASE_TICKS; i++) begin
        add_tick(pick_dt(), pick_temp());
      end
      drain();
    end
    steady = 1'b0;

    // Long run with the compressor held on at full power to build large totals
    set_thermostat(TEMP_MIN, TEMP_MIN, WATTS_MAX);
    for (int i = 0; i < SOAK_TICKS; i++) begin
      add_tick(DT_MAX, int'($urandom_range(TEMP_MAX - TEMP_MIN - 1)) + TEMP_MIN + 1);
    end
    drain();

    // Drop the power to a single watt on top of the large totals
    set_thermostat(64, 58, 1);
    for (int i = 0; i < 40; i++) begin
      add_tick(pick_dt(), pick_temp());
    end
    drain();

    if (fails == 0 && due_readings.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- hysteresis_thermostat_duty_meter.f -----
rtl/htdm_pkg.sv
rtl/htdm_in_if.sv
rtl/htdm_out_if.sv
rtl/htdm_front.sv
rtl/htdm_queue.sv
rtl/htdm_back.sv
rtl/hysteresis_thermostat_duty_meter.sv
rtl/htdm_checker.sv
dv/hysteresis_thermostat_duty_meter_tb.sv
